[sv/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// shared types and constants of the section range translator
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int SRT_MAX_SECTIONS = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int ENTRY_IDX_W = 4;
  localparam int HIT_W = 4;

  typedef enum logic [1:0] {
    MODE_LOAD      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_LOCATE    = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  // entry load bus, broadcast to every cell
  typedef struct packed {
    logic                   we;
    logic [ENTRY_IDX_W-1:0] index;
    logic [DATA_W-1:0]      raw_start;
    logic [DATA_W-1:0]      raw_length;
    logic [DATA_W-1:0]      virt_start;
    logic [DATA_W-1:0]      virt_length;
  } ld_t;

  // query word walking down the row of cells
  typedef struct packed {
    logic              valid;
    logic              translate;
    logic [DATA_W-1:0] query;
    logic              found;
    logic [HIT_W-1:0]  hit;
    logic [DATA_W-1:0] addr;
  } tok_t;

endpackage

`default_nettype wire

[sv/srt_cell.sv]
// ----------------------------------------------------------------------------
// srt_cell
// one table entry with its range compare; passes the query word on each cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cell
  import srt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ld_t              ld,
  input  wire logic [CNT_W-1:0] count,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out
);

  localparam logic [31:0] IDX_W32 = 32'(IDX);

  logic [DATA_W-1:0] raw_start_r;
  logic [DATA_W:0]   raw_end_r;
  logic [DATA_W-1:0] virt_start_r;
  logic [DATA_W:0]   virt_end_r;
  logic [DATA_W-1:0] delta_r;

  logic              sel;
  logic              active;
  logic              raw_hit;
  logic              virt_hit;
  logic              take;
  tok_t              tok_nxt;
  tok_t              tok_r;

  assign sel    = ld.we && ({{(32-ENTRY_IDX_W){1'b0}}, ld.index} == IDX_W32);
  assign active = {{(32-CNT_W){1'b0}}, count} > IDX_W32;

  // end bounds and offset are worked out once, at load time
  always_ff @(posedge clk) begin
    if (sel) begin
      raw_start_r  <= ld.raw_start;
      raw_end_r    <= {1'b0, ld.raw_start} + {1'b0, ld.raw_length};
      virt_start_r <= ld.virt_start;
      virt_end_r   <= {1'b0, ld.virt_start} + {1'b0, ld.virt_length};
      delta_r      <= ld.virt_start - ld.raw_start;
    end
  end

  assign raw_hit  = (tok_in.query >= raw_start_r) && ({1'b0, tok_in.query} <= raw_end_r);
  assign virt_hit = (tok_in.query >= virt_start_r) && ({1'b0, tok_in.query} <= virt_end_r);
  assign take     = tok_in.valid && !tok_in.found && active &&
                    (tok_in.translate ? raw_hit : virt_hit);

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.hit   = IDX_W32[HIT_W-1:0];
      tok_nxt.addr  = tok_in.translate ? (tok_in.query + delta_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[sv/section_range_translator_unit.sv]
// ----------------------------------------------------------------------------
// section_range_translator_unit
// section table with file offset translation and virtual address lookup
// ----------------------------------------------------------------------------
// A load word is taken and busy stays low. A translate or locate word walks
// the row of MAX_SECTIONS cells, one cell per cycle. Its result is on out_valid
// for one cycle, from the result register behind the last cell. Busy is high
// from the edge that took start until the result cycle, so no new word can be
// taken while a query is in the row. The receiver cannot stall: results must be
// taken on the strobe. section_count is written through cfg_valid/cfg_data,
// cfg_ready is always high; write it only while busy is low.
`default_nettype none

module section_range_translator_unit
  import srt_pkg::*;
#(
  parameter int MAX_SECTIONS = SRT_MAX_SECTIONS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_mode,
  input  wire logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  wire logic [DATA_W-1:0]      in_raw_start,
  input  wire logic [DATA_W-1:0]      in_raw_length,
  input  wire logic [DATA_W-1:0]      in_virt_start,
  input  wire logic [DATA_W-1:0]      in_virt_length,
  input  wire logic [DATA_W-1:0]      in_query_value,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [HIT_W-1:0]            out_hit_index,
  output logic [DATA_W-1:0]           out_mapped_address
);

  logic [CNT_W-1:0]        section_count_r;
  logic                    busy_r;
  logic                    busy_nxt;
  logic                    accept;
  logic                    is_query;
  ld_t                     ld;
  tok_t                    tok [MAX_SECTIONS+1];
  logic [MAX_SECTIONS-1:0] tok_valid;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [HIT_W-1:0]        out_hit_r;
  logic [DATA_W-1:0]       out_addr_r;

  assign accept   = start && !busy_r;
  assign is_query = (in_mode == MODE_TRANSLATE) || (in_mode == MODE_LOCATE);

  assign ld.we          = accept && (in_mode == MODE_LOAD);
  assign ld.index       = in_entry_index;
  assign ld.raw_start   = in_raw_start;
  assign ld.raw_length  = in_raw_length;
  assign ld.virt_start  = in_virt_start;
  assign ld.virt_length = in_virt_length;

  assign tok[0].valid     = accept && is_query;
  assign tok[0].translate = (in_mode == MODE_TRANSLATE);
  assign tok[0].query     = in_query_value;
  assign tok[0].found     = 1'b0;
  assign tok[0].hit       = '0;
  assign tok[0].addr      = '0;

  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    srt_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld     (ld),
      .count  (section_count_r),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      section_count_r <= cfg_data;
    end
  end

  // busy from query accept until the word leaves the last cell
  always_comb begin
    busy_nxt = busy_r;
    if (tok[MAX_SECTIONS].valid) begin
      busy_nxt = 1'b0;
    end
    if (tok[0].valid) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tok[MAX_SECTIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[MAX_SECTIONS].valid) begin
      out_found_r <= tok[MAX_SECTIONS].found;
      out_hit_r   <= tok[MAX_SECTIONS].hit;
      out_addr_r  <= tok[MAX_SECTIONS].addr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_hit_index      = out_hit_r;
  assign out_mapped_address = out_addr_r;

  // checks
  a_one_word_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one query word in the cell row");

  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    tok[0].valid |=> busy)
    else $error("busy not raised after query accept");

  a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_SECTIONS].valid |-> busy)
    else $error("query word left the row while not busy");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_hit_index == '0 && out_mapped_address == '0))
    else $error("miss result carries non-zero fields");

endmodule

`default_nettype wire
